/* rtl/lrukv_pkg.sv */
// lrukv_pkg: shared types and constants for the lru key-value cache
// no dependencies; imported by every module of the cache
package lrukv_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic [VAL_W-1:0] PUT_VALUE  = '0;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;  // capture the incoming transaction
    logic lookup;    // compare keys, read value memory
    logic commit;    // update ranks and stores, load result register
  } cmd_t;

endpackage

/* rtl/lrukv_ctrl.sv */
// lrukv_ctrl: sequencing state machine of the lru key-value cache
// depends on lrukv_pkg; drives the commands of lrukv_datapath
module lrukv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lrukv_pkg::cmd_t cmd_o
);
  import lrukv_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register is free when empty or being drained this cycle
  assign can_commit = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    in_stall_o   = 1'b1;
    cmd_o        = '0;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (can_commit) begin
          in_stall_o   = 1'b0;
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          if (in_valid_i) begin
            cmd_o.load_req = 1'b1;
            state_d        = ST_LOOKUP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/lrukv_datapath.sv */
// lrukv_datapath: key lanes, recency ranks, value memory and result register
// depends on lrukv_pkg; commanded by lrukv_ctrl
module lrukv_datapath #(
  parameter int unsigned Entries = lrukv_pkg::ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lrukv_pkg::cmd_t             cmd_i,
  input  logic                        cfg_write_i,
  input  logic [lrukv_pkg::CAP_W-1:0] cfg_capacity_i,
  input  logic                        req_type_i,
  input  logic [lrukv_pkg::KEY_W-1:0] lookup_key_i,
  input  logic [lrukv_pkg::VAL_W-1:0] write_value_i,
  output logic                        hit_o,
  output logic [lrukv_pkg::VAL_W-1:0] read_value_o
);
  import lrukv_pkg::*;

  localparam int unsigned IdxW  = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned OccW  = $clog2(Entries + 1);
  localparam int unsigned CmpW  = (OccW > CAP_W) ? OccW : CAP_W;

  // request register
  logic             req_put_q;
  logic [KEY_W-1:0] req_key_q;
  logic [VAL_W-1:0] req_val_q;

  // per-entry lanes
  logic [Entries-1:0] valid_q;
  logic [KEY_W-1:0]   key_q  [Entries];
  logic [RankW-1:0]   rank_q [Entries];
  logic [VAL_W-1:0]   val_mem [Entries];

  logic [OccW-1:0]  occ_q;
  logic [CAP_W-1:0] cap_q;

  // lookup results
  logic [Entries-1:0] match;
  logic [Entries-1:0] lru;
  logic               found;
  logic [IdxW-1:0]    hit_slot;
  logic [IdxW-1:0]    lru_slot;
  logic [OccW-1:0]    hit_rank;
  logic               fill;
  logic [IdxW-1:0]    tgt_d;
  logic [OccW-1:0]    old_rank_d;

  logic               found_q;
  logic               fill_q;
  logic [IdxW-1:0]    tgt_q;
  logic [OccW-1:0]    old_rank_q;
  logic [VAL_W-1:0]   rd_val_q;

  logic               touch;
  logic               hit_q;
  logic [VAL_W-1:0]   read_value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_put_q <= req_type_i;
      req_key_q <= lookup_key_i;
      req_val_q <= write_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_write_i) begin
      cap_q <= cfg_capacity_i;
    end
  end

  // parallel compare; keys of valid entries are unique, so match is one-hot
  always_comb begin
    hit_slot = '0;
    lru_slot = '0;
    hit_rank = '0;
    for (int i = 0; i < Entries; i++) begin
      match[i] = valid_q[i] && (key_q[i] == req_key_q);
      // ranks of valid entries are 0..occ-1, the oldest holds occ-1
      lru[i]   = valid_q[i] && (OccW'(rank_q[i]) == (occ_q - OccW'(1)));
      if (match[i]) begin
        hit_slot = hit_slot | IdxW'(i);
        hit_rank = hit_rank | OccW'(rank_q[i]);
      end
      if (lru[i]) begin
        lru_slot = lru_slot | IdxW'(i);
      end
    end
    found = |match;
    // capacity zero acts as one; slots fill in order, so occ is the free slot
    fill  = (occ_q != OccW'(Entries)) &&
            ((CmpW'(occ_q) < CmpW'(cap_q)) || (occ_q == '0));
    if (found) begin
      tgt_d      = hit_slot;
      old_rank_d = hit_rank;
    end else if (fill) begin
      tgt_d      = occ_q[IdxW-1:0];
      old_rank_d = OccW'(Entries);
    end else begin
      tgt_d      = lru_slot;
      old_rank_d = occ_q - OccW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      found_q    <= found;
      fill_q     <= fill;
      tgt_q      <= tgt_d;
      old_rank_q <= old_rank_d;
      rd_val_q   <= val_mem[hit_slot];
    end
  end

  // a get that misses leaves the order alone
  assign touch = found_q || (req_put_q == REQ_PUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < Entries; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (touch) begin
        for (int i = 0; i < Entries; i++) begin
          if (IdxW'(i) == tgt_q) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (OccW'(rank_q[i]) < old_rank_q)) begin
            rank_q[i] <= rank_q[i] + RankW'(1);
          end
        end
      end
      if ((req_put_q == REQ_PUT) && !found_q) begin
        valid_q[tgt_q] <= 1'b1;
        if (fill_q) begin
          occ_q <= occ_q + OccW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (req_put_q == REQ_PUT)) begin
      val_mem[tgt_q] <= req_val_q;
      if (!found_q) begin
        key_q[tgt_q] <= req_key_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q <= found_q;
      if (req_put_q == REQ_PUT) begin
        read_value_q <= PUT_VALUE;
      end else if (found_q) begin
        read_value_q <= rd_val_q;
      end else begin
        read_value_q <= MISS_VALUE;
      end
    end
  end

  assign hit_o        = hit_q;
  assign read_value_o = read_value_q;

endmodule

/* rtl/lru_key_value_cache.sv */
// lru_key_value_cache: top level of the fully associative lru key-value cache
// depends on lrukv_pkg, lrukv_ctrl and lrukv_datapath
//
// Fully associative key-value store with least-recently-used replacement.
// Each input transaction is a get (req_type 0) or a put (req_type 1) of a
// 32-bit key and returns exactly one result transaction: hit tells whether
// the key was present before the request; read_value is the stored value on
// a get hit, all ones on a get miss and zero for a put. A put to a new key
// fills the next free slot while occupancy is below the capacity register,
// else it evicts the least recent entry. Capacity zero acts as one and any
// value above Entries acts as Entries; lowering it never drops entries.
// Steps: a lookup state compares the request key against all Entries keys
// in parallel and reads the value memory, then an update state updates the
// recency ranks, the stores and the result register, which holds the result.
// A new transaction is accepted in the cycle the previous one commits, not
// before. The result register decouples the output: a stalled output only
// holds the cache once a second result is ready. No clearing pass is needed
// after reset; valid bits clear at once. The capacity port is always ready;
// the user must see that it is written only while the cache is idle; the
// block itself does not enforce this.
module lru_key_value_cache #(
  parameter int unsigned Entries = lrukv_pkg::ENTRIES_DEF  // 1 to 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [lrukv_pkg::KEY_W-1:0] lookup_key_i,
  input  logic [lrukv_pkg::VAL_W-1:0] write_value_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic [lrukv_pkg::VAL_W-1:0] read_value_o,
  // capacity register write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lrukv_pkg::CAP_W-1:0] cfg_capacity_i
);
  import lrukv_pkg::*;

  cmd_t cmd;

  // capacity writes complete immediately
  assign cfg_ready_o = 1'b1;

  lrukv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lrukv_datapath #(
    .Entries (Entries)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_write_i    (cfg_valid_i && cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .req_type_i     (req_type_i),
    .lookup_key_i   (lookup_key_i),
    .write_value_i  (write_value_i),
    .hit_o          (hit_o),
    .read_value_o   (read_value_o)
  );

endmodule
